/* hdl/bch_pkg.sv */
package bch_pkg;

  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CFG_CHORD_HOLD     = 2'd0,
    CFG_BLINK_INTERVAL = 2'd1,
    CFG_BLINK_TOTAL    = 2'd2,
    CFG_PULSE_TICKS    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] chord_hold_ticks;
    logic [15:0] blink_interval_ticks;
    logic [3:0]  blink_total;
    logic [15:0] pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic motor_on;
    logic led_on;
    logic feature_enabled;
  } status_t;

  localparam logic [31:0] CHORD_HOLD_RST     = 32'd10000;
  localparam logic [15:0] BLINK_INTERVAL_RST = 16'd100;
  localparam logic [3:0]  BLINK_TOTAL_RST    = 4'd5;
  localparam logic [15:0] PULSE_TICKS_RST    = 16'd150;

endpackage

/* hdl/bch_ifs.sv */
interface bch_item_if #(parameter int BUTTON_COUNT = 6);
  logic                    valid;
  logic                    ready;
  logic [BUTTON_COUNT-1:0] button_levels;
  logic                    link_connected;

  modport source (output valid, button_levels, link_connected, input ready);
  modport sink (input valid, button_levels, link_connected, output ready);
endinterface

interface bch_result_if #(parameter int BUTTON_COUNT = 6);
  logic                    valid;
  logic                    ready;
  logic [BUTTON_COUNT-1:0] press_mask;
  logic [BUTTON_COUNT-1:0] release_mask;
  logic                    motor_on;
  logic                    led_on;
  logic                    feature_enabled;

  modport source (output valid, press_mask, release_mask, motor_on, led_on,
                  feature_enabled, input ready);
  modport sink (input valid, press_mask, release_mask, motor_on, led_on,
                feature_enabled, output ready);
endinterface

/* hdl/button_chord_haptic_controller.sv */
// Button chord haptic controller. Each transfer on item is one millisecond tick
// of active-low button levels plus the link flag, and yields exactly one transfer
// on result with the press and release masks of that tick and the motor, LED and
// feature levels after it. A new tick is taken every clock cycle: one lane per
// button finds its edges, the lane of each chord button keeps its press stamp,
// and a single merge stage runs the blink sequencer, the pulse timer and the
// chord timer on those lane outputs within the same cycle, and the
// result is registered in a two-entry output buffer; item stalls only while both
// entries wait on result. Write the four registers through cfg_we, cfg_index and
// cfg_data only while no tick is in flight; they reset to hold 10000, blink
// interval 100, blink total 5 and pulse 150 ticks.
module button_chord_haptic_controller #(
  parameter int BUTTON_COUNT = 6,
  parameter int CHORD_COUNT  = 4,
  parameter int TIME_BITS    = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  bch_pkg::cfg_idx_t                 cfg_index,
  input  logic [bch_pkg::CFG_DATA_W-1:0]    cfg_data,
  bch_item_if.sink                          item,
  bch_result_if.source                      result
);
  import bch_pkg::*;

  cfg_t                    cfg;
  logic                    take;
  logic                    pop;
  logic [TIME_BITS-1:0]    tick_count;
  logic [TIME_BITS-1:0]    now;
  logic [BUTTON_COUNT-1:0] went_down;
  logic [BUTTON_COUNT-1:0] went_up;
  logic [TIME_BITS-1:0]    stamp_next [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] stamp_valid_next;
  status_t                 status;

  logic [BUTTON_COUNT-1:0] buf_press   [2];
  logic [BUTTON_COUNT-1:0] buf_release [2];
  status_t                 buf_status  [2];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              count;

  assign item.ready = (count != 2'd2);
  assign take       = item.valid && item.ready;
  assign pop        = result.valid && result.ready;
  assign now        = tick_count + TIME_BITS'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chord_hold_ticks     <= CHORD_HOLD_RST;
      cfg.blink_interval_ticks <= BLINK_INTERVAL_RST;
      cfg.blink_total          <= BLINK_TOTAL_RST;
      cfg.pulse_ticks          <= PULSE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHORD_HOLD:     cfg.chord_hold_ticks     <= cfg_data[31:0];
        CFG_BLINK_INTERVAL: cfg.blink_interval_ticks <= cfg_data[15:0];
        CFG_BLINK_TOTAL:    cfg.blink_total          <= cfg_data[3:0];
        CFG_PULSE_TICKS:    cfg.pulse_ticks          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (take) begin
      tick_count <= now;
    end
  end

  generate
    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
      bch_lane #(
        .TIME_BITS (TIME_BITS),
        .HAS_TIME  (i < CHORD_COUNT)
      ) u_lane (
        .clk              (clk),
        .rst              (rst),
        .take             (take),
        .link             (item.link_connected),
        .level            (item.button_levels[i]),
        .now              (now),
        .went_down        (went_down[i]),
        .went_up          (went_up[i]),
        .stamp_next       (stamp_next[i]),
        .stamp_valid_next (stamp_valid_next[i])
      );
    end
  endgenerate

  bch_merge #(
    .BUTTON_COUNT (BUTTON_COUNT),
    .CHORD_COUNT  (CHORD_COUNT),
    .TIME_BITS    (TIME_BITS)
  ) u_merge (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .link             (item.link_connected),
    .levels           (item.button_levels),
    .went_down        (went_down),
    .went_up          (went_up),
    .stamp_next       (stamp_next),
    .stamp_valid_next (stamp_valid_next),
    .now              (now),
    .cfg              (cfg),
    .status           (status)
  );

  // two-entry result buffer
  always_ff @(posedge clk) begin
    if (take) begin
      buf_press[wr_ptr]   <= went_down;
      buf_release[wr_ptr] <= went_up;
      buf_status[wr_ptr]  <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, take} - {1'b0, pop};
    end
  end

  assign result.valid           = (count != 2'd0);
  assign result.press_mask      = buf_press[rd_ptr];
  assign result.release_mask    = buf_release[rd_ptr];
  assign result.motor_on        = buf_status[rd_ptr].motor_on;
  assign result.led_on          = buf_status[rd_ptr].led_on;
  assign result.feature_enabled = buf_status[rd_ptr].feature_enabled;

endmodule

/* hdl/bch_lane.sv */
module bch_lane #(
  parameter int TIME_BITS = 32,
  parameter bit HAS_TIME  = 1'b1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic                 link,
  input  logic                 level,
  input  logic [TIME_BITS-1:0] now,
  output logic                 went_down,
  output logic                 went_up,
  output logic [TIME_BITS-1:0] stamp_next,
  output logic                 stamp_valid_next
);

  logic prev;

  assign went_down = link && prev && !level;
  assign went_up   = link && !prev && level;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= 1'b1;
    end else if (take && link) begin
      prev <= level;
    end
  end

  generate
    if (HAS_TIME) begin : g_stamp
      logic [TIME_BITS-1:0] stamp;
      logic                 stamp_valid;

      always_comb begin
        stamp_next       = stamp;
        stamp_valid_next = stamp_valid;
        if (went_down) begin
          stamp_next       = now;
          stamp_valid_next = 1'b1;
        end else if (went_up) begin
          stamp_next       = '0;
          stamp_valid_next = 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          stamp_valid <= 1'b0;
        end else if (take) begin
          stamp_valid <= stamp_valid_next;
        end
      end

      always_ff @(posedge clk) begin
        if (take) begin
          stamp <= stamp_next;
        end
      end
    end else begin : g_no_stamp
      assign stamp_next       = '0;
      assign stamp_valid_next = 1'b0;
    end
  endgenerate

endmodule

/* hdl/bch_merge.sv */
module bch_merge #(
  parameter int BUTTON_COUNT = 6,
  parameter int CHORD_COUNT  = 4,
  parameter int TIME_BITS    = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic                    link,
  input  logic [BUTTON_COUNT-1:0] levels,
  input  logic [BUTTON_COUNT-1:0] went_down,
  input  logic [BUTTON_COUNT-1:0] went_up,
  input  logic [TIME_BITS-1:0]    stamp_next [BUTTON_COUNT],
  input  logic [BUTTON_COUNT-1:0] stamp_valid_next,
  input  logic [TIME_BITS-1:0]    now,
  input  bch_pkg::cfg_t           cfg,
  output bch_pkg::status_t        status
);
  import bch_pkg::*;

  localparam int CMP_W  = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int LEVELS = $clog2(CHORD_COUNT);
  localparam int LEAVES = 1 << LEVELS;

  logic                 motor;
  logic                 led;
  logic                 feature;
  logic                 chord_seen;
  logic                 blinking;
  logic [3:0]           blinks_done;
  logic [TIME_BITS-1:0] last_blink;
  logic                 pulse_pending;
  logic [TIME_BITS-1:0] pulse_start;

  logic                 motor_next;
  logic                 led_next;
  logic                 feature_next;
  logic                 chord_seen_next;
  logic                 blinking_next;
  logic [3:0]           blinks_done_next;
  logic [TIME_BITS-1:0] last_blink_next;
  logic                 pulse_pending_next;
  logic [TIME_BITS-1:0] pulse_start_next;

  logic [TIME_BITS-1:0] blink_age;
  logic [TIME_BITS-1:0] pulse_age;
  logic [TIME_BITS-1:0] chord_age;
  logic [TIME_BITS-1:0] latest;
  logic [TIME_BITS-1:0] max_tree [2*LEAVES-1];
  logic                 blink_fire;
  logic                 pulse_over;
  logic                 chord_hit;
  logic                 chord_down;
  logic                 chord_armed;
  logic                 motor_blink;
  logic [3:0]           done_blink;

  // latest press stamp of the chord buttons, max tree
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      max_tree[LEAVES-1+i] = (i < CHORD_COUNT) ? stamp_next[i] : '0;
    end
    for (int k = LEAVES - 2; k >= 0; k--) begin
      max_tree[k] = (max_tree[2*k+1] > max_tree[2*k+2]) ? max_tree[2*k+1] : max_tree[2*k+2];
    end
  end

  assign latest      = max_tree[0];
  assign blink_age   = now - last_blink;
  assign pulse_age   = now - pulse_start;
  assign chord_age   = now - latest;
  assign chord_down  = (levels[CHORD_COUNT-1:0] == '0);
  assign chord_armed = &stamp_valid_next[CHORD_COUNT-1:0];
  assign blink_fire  = blinking && (blink_age >= TIME_BITS'(cfg.blink_interval_ticks));
  assign pulse_over  = pulse_age >= TIME_BITS'(cfg.pulse_ticks);
  assign chord_hit   = link && chord_down && chord_armed && !chord_seen
                       && (CMP_W'(chord_age) >= CMP_W'(cfg.chord_hold_ticks));

  always_comb begin
    // blink sequencer
    motor_blink      = blink_fire ? !motor : motor;
    done_blink       = (blink_fire && motor_blink) ? blinks_done + 4'd1 : blinks_done;
    last_blink_next  = blink_fire ? now : last_blink;
    blinking_next    = blinking;
    blinks_done_next = done_blink;
    motor_next       = motor_blink;
    if (blink_fire && (done_blink >= cfg.blink_total)) begin
      motor_next       = 1'b0;
      blinking_next    = 1'b0;
      blinks_done_next = 4'd0;
    end

    // press pulse timer
    pulse_start_next   = pulse_start;
    pulse_pending_next = pulse_pending;
    if (pulse_pending && !motor_next) begin
      motor_next         = 1'b1;
      pulse_start_next   = now;
      pulse_pending_next = 1'b0;
    end else if (motor_next && pulse_over) begin
      motor_next       = 1'b0;
      pulse_start_next = '0;
    end

    // button edges, highest button wins the led
    led_next = led;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (went_down[i] && feature) begin
        led_next = 1'b1;
      end else if (went_up[i]) begin
        led_next = 1'b0;
      end
    end
    if (feature && (|went_down)) begin
      pulse_pending_next = 1'b1;
    end

    // chord toggle
    feature_next    = feature ^ chord_hit;
    chord_seen_next = chord_seen;
    if (link) begin
      chord_seen_next = chord_down ? (chord_seen || chord_hit) : 1'b0;
    end
    if (chord_hit && !feature) begin
      blinking_next    = 1'b1;
      blinks_done_next = 4'd0;
      last_blink_next  = now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor         <= 1'b0;
      led           <= 1'b0;
      feature       <= 1'b0;
      chord_seen    <= 1'b0;
      blinking      <= 1'b0;
      blinks_done   <= 4'd0;
      last_blink    <= '0;
      pulse_pending <= 1'b0;
      pulse_start   <= '0;
    end else if (take) begin
      motor         <= motor_next;
      led           <= led_next;
      feature       <= feature_next;
      chord_seen    <= chord_seen_next;
      blinking      <= blinking_next;
      blinks_done   <= blinks_done_next;
      last_blink    <= last_blink_next;
      pulse_pending <= pulse_pending_next;
      pulse_start   <= pulse_start_next;
    end
  end

  assign status.motor_on        = motor_next;
  assign status.led_on          = led_next;
  assign status.feature_enabled = feature_next;

endmodule

/* verif/button_chord_haptic_controller_test.sv */
`timescale 1ns / 100ps

module button_chord_haptic_controller_test;
  import bch_pkg::*;

  typedef struct packed {
    logic [5:0] press_mask;
    logic [5:0] release_mask;
    logic       motor_on;
    logic       led_on;
    logic       feature_enabled;
  } tick_result_t;

  class tick_scoreboard;
    bit [31:0] chord_hold;
    bit [15:0] blink_interval;
    bit [3:0]  blink_total;
    bit [15:0] pulse_len;

    bit [31:0] now_tick;
    bit [5:0]  last_levels;
    bit [31:0] press_stamp [4];
    bit [3:0]  stamp_valid;
    bit        chord_latched;
    bit        feature;
    bit        blinking;
    bit [3:0]  blink_count;
    bit [31:0] last_toggle;
    bit        pulse_armed;
    bit [31:0] pulse_start;
    bit        motor;
    bit        led;

    tick_result_t expected_ticks[$];
    int failures;
    int checked;

    function new();
      chord_hold = CHORD_HOLD_RST;
      blink_interval = BLINK_INTERVAL_RST;
      blink_total = BLINK_TOTAL_RST;
      pulse_len = PULSE_TICKS_RST;
      now_tick = 0;
      last_levels = '1;
      foreach (press_stamp[i]) press_stamp[i] = 0;
      stamp_valid = 0;
      chord_latched = 0;
      feature = 0;
      blinking = 0;
      blink_count = 0;
      last_toggle = 0;
      pulse_armed = 0;
      pulse_start = 0;
      motor = 0;
      led = 0;
      failures = 0;
      checked = 0;
    endfunction

    function void configure(bit [31:0] hold, bit [15:0] intv, bit [3:0] total,
                            bit [15:0] pulse);
      chord_hold = hold;
      blink_interval = intv;
      blink_total = total;
      pulse_len = pulse;
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    // one accepted tick: blink sequencer, pulse timer, then edges and chord
    function void note_tick(bit [5:0] levels, bit link);
      tick_result_t res;
      bit [31:0] latest;
      res = '0;
      now_tick = now_tick + 1;

      if (blinking && (now_tick - last_toggle) >= 32'(blink_interval)) begin
        motor = !motor;
        if (motor) blink_count = blink_count + 4'd1;
        last_toggle = now_tick;
        if (blink_count >= blink_total) begin
          motor = 0;
          blinking = 0;
          blink_count = 0;
        end
      end

      if (pulse_armed && !motor) begin
        motor = 1;
        pulse_start = now_tick;
        pulse_armed = 0;
      end else if (motor && (now_tick - pulse_start) >= 32'(pulse_len)) begin
        motor = 0;
        pulse_start = 0;
      end

      if (link) begin
        for (int i = 0; i < 6; i++) begin
          if (levels[i] != last_levels[i]) begin
            if (!levels[i]) begin
              res.press_mask[i] = 1'b1;
              if (i < 4) begin
                press_stamp[i] = now_tick;
                stamp_valid[i] = 1'b1;
              end
              if (feature) begin
                led = 1;
                pulse_armed = 1;
              end
            end else begin
              res.release_mask[i] = 1'b1;
              if (i < 4) begin
                press_stamp[i] = 0;
                stamp_valid[i] = 1'b0;
              end
              led = 0;
            end
          end
        end
        last_levels = levels;

        if (levels[3:0] == 4'b0000) begin
          if (stamp_valid == 4'b1111) begin
            latest = 0;
            for (int i = 0; i < 4; i++)
              if (press_stamp[i] > latest) latest = press_stamp[i];
            if (!chord_latched && (now_tick - latest) >= chord_hold) begin
              feature = !feature;
              chord_latched = 1;
              if (feature) begin
                blinking = 1;
                blink_count = 0;
                last_toggle = now_tick;
              end
            end
          end
        end else begin
          chord_latched = 0;
        end
      end

      res.motor_on = motor;
      res.led_on = led;
      res.feature_enabled = feature;
      expected_ticks.push_back(res);
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t want;
      checked++;
      if (expected_ticks.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d with nothing expected: pm=%h rm=%h motor=%b led=%b feat=%b",
                   checked, got.press_mask, got.release_mask, got.motor_on, got.led_on,
                   got.feature_enabled);
        return;
      end
      want = expected_ticks.pop_front();
      if (got.press_mask !== want.press_mask || got.release_mask !== want.release_mask ||
          got.motor_on !== want.motor_on || got.led_on !== want.led_on ||
          got.feature_enabled !== want.feature_enabled) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: expected pm=%h rm=%h motor=%b led=%b feat=%b, ",
                   checked, want.press_mask, want.release_mask, want.motor_on,
                   want.led_on, want.feature_enabled,
                   "got pm=%h rm=%h motor=%b led=%b feat=%b",
                   got.press_mask, got.release_mask,
                   got.motor_on, got.led_on, got.feature_enabled);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bch_item_if #(.BUTTON_COUNT(6)) item_ch ();
  bch_result_if #(.BUTTON_COUNT(6)) result_ch ();

  button_chord_haptic_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  tick_scoreboard sb = new();
  bit calm;
  int rx_hold;
  int ticks_sent;
  logic [5:0] cur_levels;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready)
        sb.note_tick(item_ch.button_levels, item_ch.link_connected);
      if (result_ch.valid && result_ch.ready)
        sb.check_result('{result_ch.press_mask, result_ch.release_mask, result_ch.motor_on,
                          result_ch.led_on, result_ch.feature_enabled});
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      result_ch.ready = 1'b0;
      rx_hold--;
    end else begin
      result_ch.ready = calm || ($urandom_range(0, 99) >= 26);
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_tick(input logic [5:0] levels, input logic link);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 26) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.button_levels = levels;
    item_ch.link_connected = link;
    do @(posedge clk); while (!item_ch.ready);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic set_config(input logic [31:0] hold, input logic [15:0] intv,
                            input logic [3:0] total, input logic [15:0] pulse);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_CHORD_HOLD;
    cfg_data = hold;
    @(negedge clk);
    cfg_index = CFG_BLINK_INTERVAL;
    cfg_data = {16'b0, intv};
    @(negedge clk);
    cfg_index = CFG_BLINK_TOTAL;
    cfg_data = {28'b0, total};
    @(negedge clk);
    cfg_index = CFG_PULSE_TICKS;
    cfg_data = {16'b0, pulse};
    @(negedge clk);
    cfg_we = 1'b0;
    sb.configure(hold, intv, total, pulse);
  endtask

  task automatic run_random(input int n, input bit squeeze);
    int stop_at;
    int kind;
    int bsel;
    int cap;
    int hold_len;
    bit squeezed;
    stop_at = ticks_sent + n;
    squeezed = 0;
    while (ticks_sent < stop_at) begin
      if (squeeze && !squeezed && ticks_sent >= stop_at - n + 100) begin
        rx_hold = 200;
        squeezed = 1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // chord: press the four direction buttons, hold, then release at least one
        while (cur_levels[3:0] != 4'b0000) begin
          bsel = $urandom_range(0, 3);
          cur_levels[bsel] = 1'b0;
          if ($urandom_range(0, 3) == 0) cur_levels[5:4] = 2'($urandom);
          send_tick(cur_levels, $urandom_range(0, 19) != 0);
        end
        cap = (sb.chord_hold > 40) ? 40 : int'(sb.chord_hold) + 3;
        hold_len = $urandom_range(0, cap);
        repeat (hold_len) begin
          if ($urandom_range(0, 3) == 0) cur_levels[5:4] = 2'($urandom);
          send_tick(cur_levels, $urandom_range(0, 29) != 0);
        end
        cur_levels[3:0] = 4'($urandom_range(1, 15));
        send_tick(cur_levels, 1'b1);
      end else if (kind < 85) begin
        bsel = $urandom_range(0, 5);
        cur_levels[bsel] = ~cur_levels[bsel];
        send_tick(cur_levels, 1'b1);
      end else begin
        cur_levels = 6'($urandom);
        send_tick(cur_levels, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_CHORD_HOLD;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.button_levels = '1;
    item_ch.link_connected = 1'b0;
    result_ch.ready = 1'b0;
    calm = 0;
    rx_hold = 0;
    ticks_sent = 0;
    cur_levels = '1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration: edges, link down holding previous levels
    send_tick(6'h00, 1'b0);
    send_tick(6'h3f, 1'b0);
    send_tick(6'h00, 1'b1);
    send_tick(6'h3f, 1'b1);
    send_tick(6'h2a, 1'b1);
    send_tick(6'h15, 1'b1);
    send_tick(6'h00, 1'b0);
    send_tick(6'h00, 1'b1);
    send_tick(6'h3f, 1'b1);
    wait_drained();

    // shortest timings: chord toggles on, press pulse, chord toggles off
    set_config(32'd3, 16'd1, 4'd1, 16'd1);
    repeat (4) send_tick(6'h30, 1'b1);
    send_tick(6'h20, 1'b1);
    send_tick(6'h00, 1'b1);
    send_tick(6'h3f, 1'b1);
    repeat (4) send_tick(6'h30, 1'b1);
    send_tick(6'h3f, 1'b1);
    cur_levels = 6'h3f;
    wait_drained();

    calm = 1;
    set_config($urandom_range(1, 20), 16'($urandom_range(1, 8)),
               4'($urandom_range(1, 15)), 16'($urandom_range(1, 25)));
    run_random(350, 1'b0);
    wait_drained();
    calm = 0;

    set_config($urandom_range(1, 20), 16'($urandom_range(1, 8)),
               4'($urandom_range(1, 15)), 16'($urandom_range(1, 25)));
    run_random(350, 1'b1);
    wait_drained();

    set_config(32'd1, 16'd1, 4'd15, 16'hffff);
    run_random(300, 1'b0);
    wait_drained();

    set_config(32'hffffffff, 16'hffff, 4'd15, 16'd1);
    run_random(150, 1'b0);
    wait_drained();

    set_config($urandom_range(1, 30), 16'($urandom_range(1, 12)),
               4'($urandom_range(1, 6)), 16'($urandom_range(1, 40)));
    run_random(350, 1'b0);
    wait_drained();

    set_config($urandom_range(1, 15), 16'($urandom_range(1, 5)),
               4'($urandom_range(1, 15)), 16'($urandom_range(1, 10)));
    run_random(300, 1'b0);
    wait_drained();

    repeat (5) @(posedge clk);
    if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
